// ===== src/sag_pkg.sv =====
// Shared constants and types for the sigmoid activation with gain block.
package sag_pkg;

  localparam int SAG_TABLE_ENTRIES = 256;
  localparam logic signed [15:0] SAG_GAIN_RESET = 16'sd4096;

  localparam int SAG_FR_W  = 23;
  localparam int SAG_ARG_W = 24;
  localparam logic [SAG_ARG_W-1:0] SAG_ARG_MAX = 24'h800000;

  localparam int SAG_TAB_W = 17;
  localparam logic [SAG_TAB_W-1:0] SAG_ONE = 17'h10000;
  localparam logic [15:0] SAG_Y_MAX = 16'hFFFF;

  typedef struct packed {
    logic vld;
    logic last;
  } sag_tag_t;

endpackage

// ===== src/sag_if.sv =====
// Valid/ready channel interfaces for the net input and the activation result.
interface sag_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] net_in;
  logic               last_in;

  modport source (output valid, output net_in, output last_in, input ready);
  modport sink (input valid, input net_in, input last_in, output ready);
endinterface

interface sag_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] activation;
  logic signed [14:0] slope;
  logic               last_out;

  modport source (output valid, output activation, output slope, output last_out,
                  input ready);
  modport sink (input valid, input activation, input slope, input last_out,
                output ready);
endinterface

// ===== src/sag_arg.sv =====
// Argument stages: gain times net input, magnitude saturation and table position.
module sag_arg import sag_pkg::*; #(
  parameter int TABLE_ENTRIES = SAG_TABLE_ENTRIES
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  sag_tag_t                                tag_i,
  input  logic signed [15:0]                      gain,
  input  logic signed [15:0]                      net_in,
  output sag_tag_t                                tag_o,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0]      idx_o,
  output logic [SAG_FR_W-1:0]                     fr_o,
  output logic                                    neg_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
  localparam int P_W   = SAG_FR_W + IDX_W;

  sag_tag_t           tag1_r;
  sag_tag_t           tag2_r;
  logic signed [31:0] x_nxt;
  logic signed [31:0] x_r;
  logic [30:0]        mag;
  logic [SAG_ARG_W-1:0] a_sat;
  logic [P_W-1:0]     p_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [SAG_FR_W-1:0] fr_r;
  logic               neg_r;

  assign x_nxt = gain * net_in;

  always_comb begin
    mag   = x_r[31] ? 31'(-x_r) : 31'(x_r);
    a_sat = (mag > 31'(SAG_ARG_MAX)) ? SAG_ARG_MAX : mag[SAG_ARG_W-1:0];
    p_nxt = P_W'(a_sat) * P_W'(TABLE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      idx_r <= p_nxt[P_W-1:SAG_FR_W];
      fr_r  <= p_nxt[SAG_FR_W-1:0];
      neg_r <= x_r[31];
    end
  end

  assign tag_o = tag2_r;
  assign idx_o = idx_r;
  assign fr_o  = fr_r;
  assign neg_o = neg_r;

endmodule

// ===== src/sag_lut.sv =====
// Table stages: sigmoid ROM read, linear interpolation and sign mirroring.
module sag_lut import sag_pkg::*; #(
  parameter int TABLE_ENTRIES = SAG_TABLE_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  sag_tag_t                           tag_i,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] idx_i,
  input  logic [SAG_FR_W-1:0]                fr_i,
  input  logic                               neg_i,
  output sag_tag_t                           tag_o,
  output logic [15:0]                        y_o
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int PROD_W = SAG_TAB_W + SAG_FR_W;
  localparam int ROM_W  = (TABLE_ENTRIES + 1) * SAG_TAB_W;

  typedef logic [ROM_W-1:0] rom_t;

  // shift-and-subtract quotient, elaboration time only
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic rom_t build_rom();
    rom_t            t;
    longint unsigned u;
    longint unsigned term;
    longint          sum;
    longint unsigned s;
    longint unsigned d;
    t = '0;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      u    = div_u64(longint'(k) <<< 23, longint'(TABLE_ENTRIES));
      term = 64'd1 << 30;
      sum  = longint'(64'd1 << 30);
      for (int i = 1; i <= 12; i++) begin
        term = div_u64((term * u) >> 24, longint'(i));
        if (i[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      s = $unsigned(sum);
      for (int q = 0; q < 4; q++) begin
        s = (s * s + (64'd1 << 29)) >> 30;
      end
      d    = (64'd1 << 30) + s;
      t[k*SAG_TAB_W +: SAG_TAB_W] = SAG_TAB_W'(div_u64((64'd1 << 46) + (d >> 1), d));
    end
    return t;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  sag_tag_t              tag3_r;
  sag_tag_t              tag4_r;
  sag_tag_t              tag5_r;
  logic [IDX_W-1:0]      hi_addr;
  logic [SAG_TAB_W-1:0]  lo_r;
  logic [SAG_TAB_W-1:0]  hi_r;
  logic [SAG_FR_W-1:0]   fr3_r;
  logic                  neg3_r;
  logic [SAG_TAB_W-1:0]  diff;
  logic [PROD_W-1:0]     prod_nxt;
  logic [PROD_W-1:0]     prod_r;
  logic [SAG_TAB_W-1:0]  lo4_r;
  logic                  neg4_r;
  logic [PROD_W:0]       rnd;
  logic [17:0]           yv;
  logic [SAG_TAB_W-1:0]  ysat;
  logic [SAG_TAB_W-1:0]  ys;
  logic [15:0]           y_nxt;
  logic [15:0]           y_r;

  always_comb begin
    hi_addr = (idx_i == IDX_W'(TABLE_ENTRIES)) ? idx_i : IDX_W'(idx_i + 1'b1);
    diff     = (hi_r >= lo_r) ? SAG_TAB_W'(hi_r - lo_r) : '0;
    prod_nxt = PROD_W'(diff) * PROD_W'(fr3_r);
    rnd      = (PROD_W + 1)'(prod_r) + ((PROD_W + 1)'(1) << (SAG_FR_W - 1));
    yv       = 18'(lo4_r) + 18'(rnd[PROD_W:SAG_FR_W]);
    ysat     = (yv > 18'(SAG_ONE)) ? SAG_ONE : yv[SAG_TAB_W-1:0];
    ys       = neg4_r ? SAG_TAB_W'(SAG_ONE - ysat) : ysat;
    y_nxt    = (ys > SAG_TAB_W'(SAG_Y_MAX)) ? SAG_Y_MAX : ys[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r <= '0;
      tag4_r <= '0;
      tag5_r <= '0;
    end else if (en) begin
      tag3_r <= tag_i;
      tag4_r <= tag3_r;
      tag5_r <= tag4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r   <= SIG_ROM[idx_i * SAG_TAB_W +: SAG_TAB_W];
      hi_r   <= SIG_ROM[hi_addr * SAG_TAB_W +: SAG_TAB_W];
      fr3_r  <= fr_i;
      neg3_r <= neg_i;
      prod_r <= prod_nxt;
      lo4_r  <= lo_r;
      neg4_r <= neg3_r;
      y_r    <= y_nxt;
    end
  end

  assign tag_o = tag5_r;
  assign y_o   = y_r;

endmodule

// ===== src/sag_slope.sv =====
// Slope stages: y*(1-y), scale by gain, round and sign; holds the output register.
module sag_slope import sag_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  sag_tag_t           tag_i,
  input  logic [15:0]        y_i,
  input  logic signed [15:0] gain,
  output sag_tag_t           tag_o,
  output logic [15:0]        activation,
  output logic signed [14:0] slope
);

  sag_tag_t           tag6_r;
  sag_tag_t           tag7_r;
  sag_tag_t           tag8_r;
  logic [32:0]        q_nxt;
  logic [32:0]        q_r;
  logic [15:0]        y6_r;
  logic [15:0]        g_mag;
  logic [48:0]        m_nxt;
  logic [48:0]        m_r;
  logic [15:0]        y7_r;
  logic [49:0]        rsum;
  logic [14:0]        r;
  logic signed [14:0] slope_nxt;
  logic [15:0]        act_r;
  logic signed [14:0] slope_r;

  always_comb begin
    q_nxt     = 33'(y_i) * 33'(SAG_ONE - SAG_TAB_W'(y_i));
    g_mag     = gain[15] ? 16'(-gain) : 16'(gain);
    m_nxt     = 49'(g_mag) * 49'(q_r);
    rsum      = 50'(m_r) + (50'(1) << 31);
    r         = rsum[46:32];
    slope_nxt = gain[15] ? 15'(-r) : r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag6_r <= '0;
      tag7_r <= '0;
      tag8_r <= '0;
    end else if (en) begin
      tag6_r <= tag_i;
      tag7_r <= tag6_r;
      tag8_r <= tag7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r     <= q_nxt;
      y6_r    <= y_i;
      m_r     <= m_nxt;
      y7_r    <= y6_r;
      act_r   <= y7_r;
      slope_r <= slope_nxt;
    end
  end

  assign tag_o      = tag8_r;
  assign activation = act_r;
  assign slope      = slope_r;

endmodule

// ===== src/sigmoid_activation_with_gain_core.sv =====
// Logistic sigmoid activation with gain and slope, eight-stage pipeline.
//
// Usage:
//   in_ch  : valid/ready sink; one transaction carries net_in (signed Q8.8)
//            and last_in.
//   out_ch : valid/ready source; one transaction per input carries
//            activation (unsigned Q0.16), slope (signed Q3.12) and last_out.
//   cfg_we/cfg_wdata : write the gain register (signed Q4.12); write only
//            while no transaction is in flight.
// Path: a result passes the arg, lut and slope stages in order before out_ch shows it.
// Throughput: one transaction per cycle while out_ch is not stalled; the sigmoid
//   ROM is read at two addresses per cycle in a stage of its own.
// Reset: rst_n low clears all pipeline valid bits and sets gain to 1.0.
// Stall: while out_ch holds a result and ready is low, the whole pipeline
//   holds and in_ch.ready drops; nothing is lost or repeated. Bubbles in
//   the pipeline move on only while the output register is free or taken.
module sigmoid_activation_with_gain_core import sag_pkg::*; #(
  parameter int TABLE_ENTRIES = SAG_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  sag_in_if.sink             in_ch,
  sag_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);

  logic signed [15:0]  gain_r;
  logic                en;
  sag_tag_t            tag_in;
  sag_tag_t            tag_arg;
  sag_tag_t            tag_lut;
  sag_tag_t            tag_out;
  logic [IDX_W-1:0]    idx;
  logic [SAG_FR_W-1:0] fr;
  logic                neg;
  logic [15:0]         y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= SAG_GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  assign en          = !tag_out.vld || out_ch.ready;
  assign in_ch.ready = en;
  assign tag_in.vld  = in_ch.valid;
  assign tag_in.last = in_ch.last_in;

  sag_arg #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_arg (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_i  (tag_in),
    .gain   (gain_r),
    .net_in (in_ch.net_in),
    .tag_o  (tag_arg),
    .idx_o  (idx),
    .fr_o   (fr),
    .neg_o  (neg)
  );

  sag_lut #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_lut (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag_arg),
    .idx_i (idx),
    .fr_i  (fr),
    .neg_i (neg),
    .tag_o (tag_lut),
    .y_o   (y)
  );

  sag_slope u_slope (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .tag_i      (tag_lut),
    .y_i        (y),
    .gain       (gain_r),
    .tag_o      (tag_out),
    .activation (out_ch.activation),
    .slope      (out_ch.slope)
  );

  assign out_ch.valid    = tag_out.vld;
  assign out_ch.last_out = tag_out.last;

endmodule

// ===== src/sag_checker.sv =====
// Port-level assertions for the sigmoid activation core and their bind.
module sag_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        activation,
  input logic signed [14:0] slope,
  input logic               last_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(activation) && $stable(slope)
      && $stable(last_out))
    else $error("result changed while stalled");

  a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (slope >= -15'sd8192) && (slope <= 15'sd8192))
    else $error("slope out of range");

  a_zero_act_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (activation == 16'd0) |-> (slope == 15'sd0))
    else $error("nonzero slope at zero activation");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sigmoid_activation_with_gain_core sag_checker u_sag_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .activation (out_ch.activation),
  .slope      (out_ch.slope),
  .last_out   (out_ch.last_out)
);
